/* src/bga_pkg.sv */
// ----------------------------------------------------------------------------
// bga_pkg: shared types and constants for the grid automaton pass unit
// Row field width, register indexes, reset values, emit phases and the
// control group handed from the row window to the output stage.
// ----------------------------------------------------------------------------
package bga_pkg;

  // fixed field width of the row ports and default row width
  localparam int unsigned ROW_FIELD_W = 64;
  localparam int unsigned ROW_W_DEF   = 64;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARSE_THR = 2'd2;

  localparam logic       EXTRA_EN_RST   = 1'b0;
  localparam logic [3:0] WALL_THR_RST   = 4'd5;
  localparam logic [4:0] SPARSE_THR_RST = 5'd2;

  // which result a held row is producing
  localparam logic [1:0] PH_ROW_M2 = 2'd0;  // row two above the held row
  localparam logic [1:0] PH_ROW_M1 = 2'd1;  // row just above (flush only)
  localparam logic [1:0] PH_TAIL   = 2'd2;  // held row itself, bottom border

  // control from the row window to the smoother and output register
  typedef struct packed {
    logic emit;       // a result beat is produced this cycle
    logic border;     // whole row is border, all walls
    logic extra;      // sparse-area rule applies to this row
    logic frame_end;  // last row of the grid
  } bga_job_t;

endpackage

/* src/binary_grid_automaton_pass_unit.sv */
// ----------------------------------------------------------------------------
// binary_grid_automaton_pass_unit: one cave-smoothing pass, one row a beat
// Streams a wall/space grid row by row and returns the smoothed rows.
// ----------------------------------------------------------------------------
// Rows enter one per cycle unless stalled; output row r is formed when input
// row r+2 is held. Ordinary rows sustain one beat per cycle unless the output
// stalls. A row flagged last_row produces up to three result beats through
// the single output register, so it holds the input register and stalls the
// input until its last beat is taken. The first two rows of a grid give no
// result. Configuration writes take effect at once and belong only between
// grids. Bits of row_cells_i at or above ROW_WIDTH are ignored; those of
// new_row_cells_o read zero.
module binary_grid_automaton_pass_unit #(
  parameter int unsigned ROW_WIDTH = bga_pkg::ROW_W_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [bga_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bga_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input rows
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bga_pkg::ROW_FIELD_W-1:0]    row_cells_i,
  input  logic                               last_row_i,
  // result rows
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bga_pkg::ROW_FIELD_W-1:0]    new_row_cells_o,
  output logic                               frame_end_o
);
  import bga_pkg::*;

  localparam logic [ROW_FIELD_W-1:0] RowMask = {ROW_FIELD_W{1'b1}} >> (ROW_FIELD_W - ROW_WIDTH);

  logic                        extra_en_q;
  logic [3:0]                  wall_thr_q;
  logic [4:0]                  sparse_thr_q;

  bga_job_t                    job;
  logic [4:0][ROW_WIDTH-1:0]   nb;
  logic [ROW_WIDTH-1:0]        smooth_row;

  logic                        out_valid_q;
  logic [ROW_FIELD_W-1:0]      out_row_q;
  logic                        out_end_q;
  logic                        out_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_en_q   <= EXTRA_EN_RST;
      wall_thr_q   <= WALL_THR_RST;
      sparse_thr_q <= SPARSE_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXTRA_EN:   extra_en_q   <= cfg_wdata_i[0];
        CFG_WALL_THR:   wall_thr_q   <= cfg_wdata_i[3:0];
        CFG_SPARSE_THR: sparse_thr_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  assign out_ready = !out_valid_q || !out_stall_i;

  bga_window #(
    .ROW_WIDTH (ROW_WIDTH)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .row_cells_i (row_cells_i),
    .last_row_i  (last_row_i),
    .extra_en_i  (extra_en_q),
    .out_ready_i (out_ready),
    .job_o       (job),
    .nb_o        (nb)
  );

  bga_smooth #(
    .ROW_WIDTH (ROW_WIDTH)
  ) u_smooth (
    .nb_i         (nb),
    .border_i     (job.border),
    .extra_i      (job.extra),
    .wall_thr_i   (wall_thr_q),
    .sparse_thr_i (sparse_thr_q),
    .row_o        (smooth_row)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= job.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && job.emit) begin
      out_row_q <= ROW_FIELD_W'(smooth_row);
      out_end_q <= job.frame_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign new_row_cells_o = out_row_q;
  assign frame_end_o     = out_end_q;

`ifndef SYNTH
  // the closing row of a grid is all border
  a_end_all_wall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> new_row_cells_o == RowMask)
    else $error("frame_end beat is not an all-wall row");

  // nothing outside the configured row width
  a_no_stray_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (new_row_cells_o & ~RowMask) == '0)
    else $error("result row has bits beyond ROW_WIDTH");

  // side columns are always walls
  a_side_walls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> new_row_cells_o[0] && new_row_cells_o[ROW_WIDTH-1])
    else $error("result row has an open side column");
`endif

endmodule

/* src/bga_smooth.sv */
// ----------------------------------------------------------------------------
// bga_smooth: one-row smoothing datapath
// Per column: 3x3 wall count against the wall threshold, and the 21-cell
// (5x5 less corners) count against the sparse threshold. Pure logic.
// ----------------------------------------------------------------------------
module bga_smooth #(
  parameter int unsigned ROW_WIDTH = bga_pkg::ROW_W_DEF
) (
  input  logic [4:0][ROW_WIDTH-1:0] nb_i,        // [0] = row r-2 .. [4] = row r+2
  input  logic                      border_i,
  input  logic                      extra_i,
  input  logic [3:0]                wall_thr_i,
  input  logic [4:0]                sparse_thr_i,
  output logic [ROW_WIDTH-1:0]      row_o
);
  import bga_pkg::*;

  for (genvar gj = 0; gj < ROW_WIDTH; gj++) begin : g_col
    if (gj == 0 || gj == ROW_WIDTH - 1) begin : g_edge
      // left and right columns are always walls
      assign row_o[gj] = 1'b1;
    end else begin : g_core
      logic [3:0] c9;
      logic       sp;

      // 3x3 neighbourhood count, center included
      always_comb begin
        c9 = '0;
        for (int di = 1; di <= 3; di++) begin
          for (int dj = -1; dj <= 1; dj++) begin
            c9 = c9 + 4'(nb_i[di][gj+dj]);
          end
        end
      end

      if (gj >= 2 && gj <= ROW_WIDTH - 3) begin : g_sparse
        logic [4:0] c21;

        // 5x5 count without the four corners
        always_comb begin
          c21 = '0;
          for (int di = 0; di <= 4; di++) begin
            for (int dj = -2; dj <= 2; dj++) begin
              if (!((di == 0 || di == 4) && (dj == -2 || dj == 2))) begin
                c21 = c21 + 5'(nb_i[di][gj+dj]);
              end
            end
          end
        end

        assign sp = extra_i && (c21 <= sparse_thr_i);
      end else begin : g_nosparse
        assign sp = 1'b0;
      end

      assign row_o[gj] = border_i | (c9 >= wall_thr_i) | sp;
    end
  end

endmodule

/* src/bga_window.sv */
// ----------------------------------------------------------------------------
// bga_window: input register, row window and result sequencing
// Holds the accepted row until all of its result beats have left, then
// shifts it into the four-row window (or clears the window on a last row).
// ----------------------------------------------------------------------------
module bga_window #(
  parameter int unsigned ROW_WIDTH = bga_pkg::ROW_W_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [bga_pkg::ROW_FIELD_W-1:0]      row_cells_i,
  input  logic                                 last_row_i,
  input  logic                                 extra_en_i,
  input  logic                                 out_ready_i,
  output bga_pkg::bga_job_t                    job_o,
  output logic [4:0][ROW_WIDTH-1:0]            nb_o
);
  import bga_pkg::*;

  logic                 s1_valid_q;
  logic [ROW_WIDTH-1:0] x_q;
  logic                 last_q;
  logic [1:0]           phase_q;
  logic [ROW_WIDTH-1:0] win_q [4];   // [0] newest
  logic [1:0]           rows_seen_q;
  logic                 deep_q;

  logic [1:0] ph_a, cur;
  logic       has_out, fin, fire, retire, accept;

  // skip the phases that a short grid does not have
  always_comb begin
    ph_a = phase_q;
    if (last_q && ph_a == PH_ROW_M2 && !rows_seen_q[1]) ph_a = PH_ROW_M1;
    cur = ph_a;
    if (last_q && ph_a == PH_ROW_M1 && rows_seen_q == 2'd0) cur = PH_TAIL;
  end

  assign has_out    = last_q || rows_seen_q[1];
  assign fin        = !last_q || (cur == PH_TAIL);
  assign fire       = s1_valid_q && (!has_out || out_ready_i);
  assign retire     = fire && fin;
  assign in_stall_o = s1_valid_q && !retire;
  assign accept     = in_valid_i && !in_stall_o;

  // neighbourhood rows and flags for the current beat
  always_comb begin
    job_o.emit      = fire && has_out;
    job_o.border    = 1'b1;
    job_o.extra     = 1'b0;
    job_o.frame_end = 1'b0;
    nb_o[0] = win_q[3];
    nb_o[1] = win_q[2];
    nb_o[2] = win_q[1];
    nb_o[3] = win_q[0];
    nb_o[4] = x_q;
    case (cur)
      PH_ROW_M2: begin
        job_o.border = (rows_seen_q == 2'd2);
        job_o.extra  = extra_en_i && deep_q;
      end
      PH_ROW_M1: begin
        nb_o[0]      = win_q[2];
        nb_o[1]      = win_q[1];
        nb_o[2]      = win_q[0];
        nb_o[3]      = x_q;
        nb_o[4]      = '0;
        job_o.border = (rows_seen_q == 2'd1);
      end
      default: begin
        job_o.frame_end = 1'b1;
      end
    endcase
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      phase_q     <= PH_ROW_M2;
      rows_seen_q <= '0;
      deep_q      <= 1'b0;
      for (int i = 0; i < 4; i++) win_q[i] <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        phase_q    <= PH_ROW_M2;
      end else if (retire) begin
        s1_valid_q <= 1'b0;
      end else if (fire) begin
        phase_q <= cur + 2'd1;
      end

      if (retire) begin
        if (last_q) begin
          rows_seen_q <= '0;
          deep_q      <= 1'b0;
          for (int i = 0; i < 4; i++) win_q[i] <= '0;
        end else begin
          win_q[3] <= win_q[2];
          win_q[2] <= win_q[1];
          win_q[1] <= win_q[0];
          win_q[0] <= x_q;
          if (rows_seen_q == 2'd3) deep_q <= 1'b1;
          else rows_seen_q <= rows_seen_q + 2'd1;
        end
      end
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= row_cells_i[ROW_WIDTH-1:0];
      last_q <= last_row_i;
    end
  end

endmodule

/* dv/binary_grid_automaton_pass_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_grid_automaton_pass_unit_tb: self-checking bench for the pass unit
// Streams grids of random height and density through the block under a
// range of rule settings and idle/stall mixes. Every smoothed row is checked
// against a cycle-free model of the cave-smoothing pass kept in the bench.
// ----------------------------------------------------------------------------
module binary_grid_automaton_pass_unit_tb;

  import bga_pkg::*;

  localparam int unsigned  ROW_W          = ROW_W_DEF;
  localparam logic [63:0]  ROW_MASK       = {64{1'b1}} >> (64 - ROW_W);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int unsigned  SETTLE_CYCLES  = 8;
  localparam int unsigned  CYCLE_LIMIT    = 200000;

  typedef struct {
    logic [ROW_FIELD_W-1:0] cells;
    logic                   last;
  } grid_row_t;

  typedef struct packed {
    logic [ROW_FIELD_W-1:0] cells;
    logic                   frame_end;
  } smoothed_row_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [ROW_FIELD_W-1:0]   row_cells_i = '0;
  logic                     last_row_i  = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [ROW_FIELD_W-1:0]   new_row_cells_o;
  logic                     frame_end_o;

  binary_grid_automaton_pass_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .row_cells_i    (row_cells_i),
    .last_row_i     (last_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .new_row_cells_o(new_row_cells_o),
    .frame_end_o    (frame_end_o)
  );

  // rows waiting to be sent, head is the one on the port
  grid_row_t     pending_rows_q[$];
  // smoothed rows the block still owes
  smoothed_row_t smoothed_q[$];

  // mirror of the rule registers
  logic       sparse_rule_on = EXTRA_EN_RST;
  logic [3:0] wall_min       = WALL_THR_RST;
  logic [4:0] sparse_max     = SPARSE_THR_RST;

  // mirror of the row window
  logic [63:0] held_rows [4] = '{64'd0, 64'd0, 64'd0, 64'd0};
  int unsigned rows_in_grid  = 0;
  logic        window_full   = 1'b0;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // one smoothing pass over the middle row of five (nb[2] is the row)
  function automatic logic [63:0] smooth_rows(input logic [4:0][63:0] nb,
                                              input bit border,
                                              input bit sparse_on);
    logic [63:0] res;
    int          cnt;
    int          c21;
    bit          wall;
    if (border) return ROW_MASK;
    res          = '0;
    res[0]       = 1'b1;
    res[ROW_W-1] = 1'b1;
    for (int j = 1; j <= ROW_W - 2; j++) begin
      cnt = 0;
      for (int di = 1; di <= 3; di++)
        for (int dj = -1; dj <= 1; dj++)
          cnt += nb[di][j+dj];
      wall = (cnt >= wall_min);
      // sparse-area rule: 5x5 minus the corners
      if (sparse_on && j >= 2 && j <= ROW_W - 3) begin
        c21 = 0;
        for (int di = -2; di <= 2; di++)
          for (int dj = -2; dj <= 2; dj++)
            if (!((di == 2 || di == -2) && (dj == 2 || dj == -2)))
              c21 += nb[2+di][j+dj];
        if (c21 <= sparse_max) wall = 1'b1;
      end
      res[j] = wall;
    end
    return res & ROW_MASK;
  endfunction

  // append one owed result beat at the tail
  function automatic void owe_row(input logic [63:0] cells, input logic fe);
    smoothed_row_t s;
    s.cells     = cells;
    s.frame_end = fe;
    smoothed_q.insert(smoothed_q.size(), s);
  endfunction

  // expected results caused by one accepted input row
  function automatic void predict_grid_row(input logic [63:0] cells,
                                           input logic last);
    logic [63:0]      x;
    int unsigned      k;
    logic [4:0][63:0] nb;
    x = cells & ROW_MASK;
    k = rows_in_grid;
    if (k >= 2) begin
      nb = {x, held_rows[0], held_rows[1], held_rows[2], held_rows[3]};
      owe_row(smooth_rows(nb, k == 2, sparse_rule_on && window_full), 1'b0);
    end
    if (last) begin
      // flush: row above the last one, then the bottom border row
      if (k >= 1) begin
        nb = {64'd0, x, held_rows[0], held_rows[1], held_rows[2]};
        owe_row(smooth_rows(nb, k == 1, 1'b0), 1'b0);
      end
      owe_row(ROW_MASK, 1'b1);
      held_rows    = '{64'd0, 64'd0, 64'd0, 64'd0};
      rows_in_grid = 0;
      window_full  = 1'b0;
      return;
    end
    held_rows[3] = held_rows[2];
    held_rows[2] = held_rows[1];
    held_rows[1] = held_rows[0];
    held_rows[0] = x;
    if (rows_in_grid == 3) window_full = 1'b1;
    else rows_in_grid++;
  endfunction

  // row driver: predicts on each accepted beat, then offers the next row
  always @(posedge clk_i) begin : drive_rows
    bit fire;
    if (rst_ni) begin
      fire = in_valid_i && !in_stall_o;
      if (fire) begin
        predict_grid_row(pending_rows_q[0].cells, pending_rows_q[0].last);
        void'(pending_rows_q.pop_front());
      end
      if (!in_valid_i || fire) begin
        if (pending_rows_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i  <= 1'b1;
          row_cells_i <= pending_rows_q[0].cells;
          last_row_i  <= pending_rows_q[0].last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin : check_rows
    smoothed_row_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (smoothed_q.size() == 0) begin
        $error("unexpected result beat: new_row_cells=%h frame_end=%b",
               new_row_cells_o, frame_end_o);
        fail_count++;
      end else begin
        want = smoothed_q.pop_front();
        if (new_row_cells_o !== want.cells) begin
          $error("new_row_cells mismatch: expected %h, actual %h",
                 want.cells, new_row_cells_o);
          fail_count++;
        end
        if (frame_end_o !== want.frame_end) begin
          $error("frame_end mismatch: expected %b, actual %b",
                 want.frame_end, frame_end_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic queue_row(input logic [63:0] cells, input logic last);
    grid_row_t r;
    r.cells = cells;
    r.last  = last;
    pending_rows_q.insert(pending_rows_q.size(), r);
  endtask

  // register write, mirrored at once since the block is idle
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_EXTRA_EN:   sparse_rule_on = val[0];
      CFG_WALL_THR:   wall_min       = val[3:0];
      CFG_SPARSE_THR: sparse_max     = val[4:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // all rows sent and all results back, then let the pipe settle
  task automatic wait_drained();
    while (pending_rows_q.size() != 0 || smoothed_q.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // whole grids of random height; density is chosen per grid, sometimes per row
  task automatic fill_random_grids(input int unsigned target);
    int unsigned added;
    int unsigned height;
    int unsigned pick;
    logic [63:0] cells;
    added = 0;
    while (added < target) begin
      height = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(8, 1);
      pick   = $urandom_range(5);
      for (int r = 0; r < height; r++) begin
        if ($urandom_range(3) == 0) pick = $urandom_range(5);
        case (pick)
          0:       cells = '0;
          1:       cells = '1;
          3:       cells = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
          4:       cells = {$urandom, $urandom} | {$urandom, $urandom};
          5:       cells = ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
          default: cells = {$urandom, $urandom};
        endcase
        queue_row(cells, r == height - 1);
        added++;
      end
    end
  endtask

  // per-phase settings: idle and stall mix and rule registers
  int unsigned tx_idle_tab  [8] = '{0, 65, 0, 37, 0, 65, 0, 37};
  int unsigned rx_stall_tab [8] = '{0, 0, 65, 37, 0, 0, 65, 37};
  logic [4:0]  extra_tab    [8] = '{5'd1, 5'd0, 5'd1, 5'd1, 5'd0, 5'd1, 5'd1, 5'd1};
  logic [4:0]  wall_tab     [8] = '{5'd5, 5'd0, 5'd9, 5'd15, 5'd3, 5'd4, 5'd6, 5'd2};
  logic [4:0]  sparse_tab   [8] = '{5'd2, 5'd0, 5'd21, 5'd31, 5'd8, 5'd21, 5'd0, 5'd10};

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset rule values: grids of one, two, three, four and six rows
    queue_row('1, 1'b1);
    queue_row('0, 1'b0);
    queue_row('1, 1'b1);
    queue_row('0, 1'b0);
    queue_row('1, 1'b0);
    queue_row('0, 1'b1);
    queue_row(64'h5555_5555_5555_5555, 1'b0);
    queue_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_row('1, 1'b0);
    queue_row('0, 1'b1);
    queue_row('0, 1'b0);
    queue_row('1, 1'b0);
    queue_row(64'h00FF_00FF_00FF_00FF, 1'b0);
    queue_row('0, 1'b0);
    queue_row({$urandom, $urandom}, 1'b0);
    queue_row('1, 1'b1);
    wait_drained();

    // directed, sparse rule on: nearly empty grid fills in the deep rows
    write_cfg(CFG_EXTRA_EN, 5'd1);
    write_cfg(CFG_WALL_THR, 5'd5);
    write_cfg(CFG_SPARSE_THR, 5'd2);
    for (int r = 0; r < 6; r++) queue_row(r == 3 ? 64'h8000_0001_0010_0001 : '0, r == 5);

    // random phases
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      write_cfg(CFG_EXTRA_EN, extra_tab[p]);
      write_cfg(CFG_WALL_THR, wall_tab[p]);
      write_cfg(CFG_SPARSE_THR, sparse_tab[p]);
      if (p == 4) write_cfg(CFG_UNUSED_IDX, 5'd31);
      tx_idle_pct  = tx_idle_tab[p];
      rx_stall_pct = rx_stall_tab[p];
      if (p == 3) begin
        // sender holds off until every owed row is back
        fill_random_grids(25);
        wait_drained();
        fill_random_grids(25);
      end else begin
        fill_random_grids(50);
      end
    end
    wait_drained();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
